[src/dtrs_pkg.sv]
package dtrs_pkg;

  localparam int IDX_W   = 9;
  localparam int DATA_W  = 8;
  localparam int MLEN_W  = 16;
  localparam int TALLY_W = 32;
  localparam int ACT_W   = 2;
  localparam int MODX_W  = 10;
  localparam int MODK_W  = 4;
  localparam int CMD_Q_DEPTH = 2;
  localparam int RES_Q_DEPTH = 2;

  localparam logic [MODK_W-1:0] MOD_K_TOP = 4'd8;
  localparam logic [IDX_W-1:0]  RING_LEN_RESET = 9'd256;

  localparam logic [ACT_W-1:0] ACT_BYTE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DONE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ERR   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_FETCH = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [DATA_W-1:0] data_byte;
    logic [MLEN_W-1:0] msg_len;
    logic              first_flag;
    logic              last_flag;
    logic [IDX_W-1:0]  dma_remaining;
    logic [7:0]        fetch_index;
    logic              has_result;
  } cmd_t;

  typedef struct packed {
    logic               accepted;
    logic               start_segment;
    logic [7:0]         seg_start;
    logic [IDX_W-1:0]   seg_len;
    logic               busy_out;
    logic [TALLY_W-1:0] error_tally_out;
    logic [DATA_W-1:0]  read_data;
  } res_t;

  typedef struct packed {
    logic              start;
    logic [MODX_W-1:0] x;
    logic [IDX_W-1:0]  m;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] r;
  } mod_rsp_t;

endpackage

[src/dma_tx_ring_segmenter_top.sv]
// Transmit ring buffer in front of a DMA engine. Words are pushed into a two-entry command
// queue and results are popped from a two-entry result queue, so both sides may stall freely.
// A sequencer works on one word at a time. An error word counts into the error tally, a
// completion word frees the engine or chains a segment, and a fetch reads the ring. A
// message byte is written or dropped, and a first byte that comes while the engine is busy
// has its message start reduced first. A last byte rejects the message, queues it behind a
// busy engine, or queues it and launches a segment. Each ring index reduction goes through
// one shared remainder unit, which takes a fast path while the operand lies below twice the
// ring length, and otherwise runs a shift-and-subtract loop, as after a ring length change.
// Ring contents are undefined until written; there is no clearing pass after reset.
// The user must write ring_length through cfg_wen/cfg_wdata only while no word is in flight;
// the block itself does not enforce this.
module dma_tx_ring_segmenter_top #(
  parameter int RING_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wen,
  input  logic [dtrs_pkg::IDX_W-1:0]   cfg_wdata,
  input  logic                         push,
  output logic                         full,
  input  logic [dtrs_pkg::ACT_W-1:0]   action,
  input  logic [dtrs_pkg::DATA_W-1:0]  data_byte,
  input  logic [dtrs_pkg::MLEN_W-1:0]  msg_len,
  input  logic                         first_flag,
  input  logic                         last_flag,
  input  logic [dtrs_pkg::IDX_W-1:0]   dma_remaining,
  input  logic [7:0]                   fetch_index,
  output logic                         empty,
  input  logic                         pop,
  output logic                         accepted,
  output logic                         start_segment,
  output logic [7:0]                   seg_start,
  output logic [dtrs_pkg::IDX_W-1:0]   seg_len,
  output logic                         busy_out,
  output logic [dtrs_pkg::TALLY_W-1:0] error_tally_out,
  output logic [dtrs_pkg::DATA_W-1:0]  read_data
);

  logic [dtrs_pkg::IDX_W-1:0]        ring_length;
  logic                              cmd_valid;
  dtrs_pkg::cmd_t                    cmd;
  logic                              cmd_pop;
  logic                              res_push;
  dtrs_pkg::res_t                    res;
  logic                              res_full;
  logic [$bits(dtrs_pkg::res_t)-1:0] res_q;
  dtrs_pkg::res_t                    head;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_length <= dtrs_pkg::RING_LEN_RESET;
    end else if (cfg_wen) begin
      ring_length <= cfg_wdata;
    end
  end

  dtrs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .action        (action),
    .data_byte     (data_byte),
    .msg_len       (msg_len),
    .first_flag    (first_flag),
    .last_flag     (last_flag),
    .dma_remaining (dma_remaining),
    .fetch_index   (fetch_index),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  dtrs_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .res_space   (!res_full),
    .res_push    (res_push),
    .res         (res),
    .ring_length (ring_length)
  );

  dtrs_fifo #(
    .W     ($bits(dtrs_pkg::res_t)),
    .DEPTH (dtrs_pkg::RES_Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_q),
    .empty (empty)
  );

  assign head            = dtrs_pkg::res_t'(res_q);
  assign accepted        = head.accepted;
  assign start_segment   = head.start_segment;
  assign seg_start       = head.seg_start;
  assign seg_len         = head.seg_len;
  assign busy_out        = head.busy_out;
  assign error_tally_out = head.error_tally_out;
  assign read_data       = head.read_data;

endmodule

[src/dtrs_ram.sv]
module dtrs_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/dtrs_fifo.sv]
module dtrs_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/dtrs_front.sv]
module dtrs_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [dtrs_pkg::ACT_W-1:0]  action,
  input  logic [dtrs_pkg::DATA_W-1:0] data_byte,
  input  logic [dtrs_pkg::MLEN_W-1:0] msg_len,
  input  logic                        first_flag,
  input  logic                        last_flag,
  input  logic [dtrs_pkg::IDX_W-1:0]  dma_remaining,
  input  logic [7:0]                  fetch_index,
  output logic                        cmd_valid,
  output dtrs_pkg::cmd_t              cmd,
  input  logic                        cmd_pop
);

  dtrs_pkg::cmd_t                  word;
  logic [$bits(dtrs_pkg::cmd_t)-1:0] q_data;
  logic                            q_empty;

  // a message byte without the last mark produces no result
  always_comb begin
    word.action        = action;
    word.data_byte     = data_byte;
    word.msg_len       = msg_len;
    word.first_flag    = first_flag;
    word.last_flag     = last_flag;
    word.dma_remaining = dma_remaining;
    word.fetch_index   = fetch_index;
    word.has_result    = !((action == dtrs_pkg::ACT_BYTE) && !last_flag);
  end

  dtrs_fifo #(
    .W     ($bits(dtrs_pkg::cmd_t)),
    .DEPTH (dtrs_pkg::CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (word),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (q_data),
    .empty (q_empty)
  );

  assign cmd_valid = !q_empty;
  assign cmd       = dtrs_pkg::cmd_t'(q_data);

endmodule

[src/dtrs_mod.sv]
module dtrs_mod (
  input  logic               clk,
  input  logic               rst,
  input  dtrs_pkg::mod_req_t req,
  output dtrs_pkg::mod_rsp_t rsp
);

  localparam int SW = 2 * dtrs_pkg::IDX_W;

  logic                        run;
  logic                        run_next;
  logic                        done;
  logic                        done_next;
  logic [dtrs_pkg::MODK_W-1:0] k;
  logic [dtrs_pkg::MODK_W-1:0] k_next;
  logic [dtrs_pkg::MODX_W-1:0] acc;
  logic [dtrs_pkg::MODX_W-1:0] acc_next;
  logic [dtrs_pkg::IDX_W-1:0]  m;
  logic [dtrs_pkg::IDX_W-1:0]  m_next;
  logic [SW-1:0]               wide;

  always_comb begin
    run_next  = run;
    done_next = 1'b0;
    k_next    = k;
    acc_next  = acc;
    m_next    = m;
    wide      = SW'(m) << k;
    if (run) begin
      if (SW'(acc) >= wide) begin
        acc_next = acc - dtrs_pkg::MODX_W'(wide);
      end
      if (k == '0) begin
        run_next  = 1'b0;
        done_next = 1'b1;
      end else begin
        k_next = k - 1'b1;
      end
    end else if (req.start) begin
      m_next = req.m;
      if (req.x < dtrs_pkg::MODX_W'(req.m)) begin
        acc_next  = req.x;
        done_next = 1'b1;
      end else if (req.x < {req.m, 1'b0}) begin
        acc_next  = req.x - dtrs_pkg::MODX_W'(req.m);
        done_next = 1'b1;
      end else begin
        acc_next = req.x;
        k_next   = dtrs_pkg::MOD_K_TOP;
        run_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      run  <= run_next;
      done <= done_next;
    end
    k   <= k_next;
    acc <= acc_next;
    m   <= m_next;
  end

  assign rsp.done = done;
  assign rsp.r    = acc[dtrs_pkg::IDX_W-1:0];

endmodule

[src/dtrs_back.sv]
module dtrs_back #(
  parameter int RING_DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  input  dtrs_pkg::cmd_t             cmd,
  output logic                       cmd_pop,
  input  logic                       res_space,
  output logic                       res_push,
  output dtrs_pkg::res_t             res,
  input  logic [dtrs_pkg::IDX_W-1:0] ring_length
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int IW = dtrs_pkg::IDX_W;
  localparam int XW = dtrs_pkg::MODX_W;
  localparam int OW = 18;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DISP   = 4'd1;
  localparam logic [3:0] ST_MS     = 4'd2;
  localparam logic [3:0] ST_BYTE   = 4'd3;
  localparam logic [3:0] ST_WP     = 4'd4;
  localparam logic [3:0] ST_TAIL   = 4'd5;
  localparam logic [3:0] ST_WT     = 4'd6;
  localparam logic [3:0] ST_LAUNCH = 4'd7;
  localparam logic [3:0] ST_FETCH  = 4'd8;
  localparam logic [3:0] ST_REPORT = 4'd9;

  logic [3:0]                   state, state_next;
  dtrs_pkg::cmd_t               c, c_next;
  dtrs_pkg::res_t               rep, rep_next;
  logic [IW-1:0]                write_top, write_top_next;
  logic [IW-1:0]                send_top, send_top_next;
  logic                         busy, busy_next;
  logic [dtrs_pkg::TALLY_W-1:0] error_tally, error_tally_next;
  logic                         msg_ok, msg_ok_next;
  logic [IW-1:0]                write_ptr, write_ptr_next;
  logic [IW-1:0]                msg_start, msg_start_next;
  logic [IW-1:0]                held_len, held_len_next;
  logic [IW-1:0]                held_count, held_count_next;

  logic [IW-1:0]                len;
  logic                         len_ok;
  logic                         fetch_ok;
  logic                         wp_ok;
  logic signed [OW-1:0]         occ;
  logic signed [OW-1:0]         room;
  logic                         fit;

  dtrs_pkg::mod_req_t           mod_req;
  dtrs_pkg::mod_rsp_t           mod_rsp;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [AW-1:0]                ram_raddr;
  logic [dtrs_pkg::DATA_W-1:0]  ram_rdata;

  // ring length in use, held between two and the ring depth
  always_comb begin
    if (ring_length < IW'(2)) begin
      len = IW'(2);
    end else if (32'(ring_length) > RING_DEPTH) begin
      len = IW'(RING_DEPTH);
    end else begin
      len = ring_length;
    end
  end

  assign len_ok   = (c.msg_len != '0) && (32'(c.msg_len) <= 32'(len));
  assign fetch_ok = 32'(c.fetch_index) < RING_DEPTH;
  assign wp_ok    = 32'(write_ptr) < RING_DEPTH;

  // bytes in flight while the engine is busy, and room left for a new word run
  always_comb begin
    if (send_top > write_top) begin
      occ = $signed(OW'(write_top)) + $signed(OW'(len)) + $signed(OW'(c.dma_remaining))
            - $signed(OW'(send_top));
    end else begin
      occ = $signed(OW'(write_top)) - $signed(OW'(send_top))
            + $signed(OW'(c.dma_remaining));
    end
    room = $signed(OW'(len)) - occ;
    fit  = !occ[OW-1] && ($signed(OW'(c.msg_len)) <= room);
  end

  always_comb begin
    state_next       = state;
    c_next           = c;
    rep_next         = rep;
    write_top_next   = write_top;
    send_top_next    = send_top;
    busy_next        = busy;
    error_tally_next = error_tally;
    msg_ok_next      = msg_ok;
    write_ptr_next   = write_ptr;
    msg_start_next   = msg_start;
    held_len_next    = held_len;
    held_count_next  = held_count;
    cmd_pop          = 1'b0;
    res_push         = 1'b0;
    mod_req.start    = 1'b0;
    mod_req.x        = '0;
    mod_req.m        = len;
    ram_we           = 1'b0;
    ram_waddr        = AW'(write_ptr);
    ram_raddr        = AW'(c.fetch_index);
    res                 = rep;
    res.busy_out        = busy;
    res.error_tally_out = error_tally;

    case (state)
      ST_IDLE: begin
        if (cmd_valid && res_space) begin
          cmd_pop    = 1'b1;
          c_next     = cmd;
          rep_next   = '0;
          state_next = ST_DISP;
        end
      end
      ST_DISP: begin
        case (c.action)
          dtrs_pkg::ACT_BYTE: begin
            state_next = ST_BYTE;
            if (c.first_flag) begin
              msg_ok_next = 1'b0;
              if (len_ok) begin
                if (busy) begin
                  if (fit) begin
                    mod_req.start = 1'b1;
                    mod_req.x     = XW'(write_top) + XW'(1);
                    state_next    = ST_MS;
                  end
                end else begin
                  write_top_next  = '0;
                  send_top_next   = '0;
                  msg_start_next  = '0;
                  write_ptr_next  = '0;
                  msg_ok_next     = 1'b1;
                  held_len_next   = c.msg_len[IW-1:0];
                  held_count_next = '0;
                end
              end
            end
          end
          dtrs_pkg::ACT_DONE: begin
            state_next = ST_REPORT;
            if (busy) begin
              if (send_top != write_top) begin
                mod_req.start = 1'b1;
                mod_req.x     = XW'(send_top) + XW'(1);
                state_next    = ST_LAUNCH;
              end else begin
                busy_next = 1'b0;
              end
            end
          end
          dtrs_pkg::ACT_ERR: begin
            error_tally_next = error_tally + 1'b1;
            state_next       = ST_REPORT;
          end
          default: begin
            state_next = ST_FETCH;
          end
        endcase
      end
      ST_MS: begin
        if (mod_rsp.done) begin
          msg_start_next  = mod_rsp.r;
          write_ptr_next  = mod_rsp.r;
          msg_ok_next     = 1'b1;
          held_len_next   = c.msg_len[IW-1:0];
          held_count_next = '0;
          state_next      = ST_BYTE;
        end
      end
      ST_BYTE: begin
        state_next = ST_TAIL;
        if (msg_ok && (held_count < held_len)) begin
          ram_we          = wp_ok;
          held_count_next = held_count + 1'b1;
          mod_req.start   = 1'b1;
          mod_req.x       = XW'(write_ptr) + XW'(1);
          state_next      = ST_WP;
        end
      end
      ST_WP: begin
        if (mod_rsp.done) begin
          write_ptr_next = mod_rsp.r;
          state_next     = ST_TAIL;
        end
      end
      ST_TAIL: begin
        if (!c.last_flag) begin
          state_next = ST_IDLE;
        end else begin
          msg_ok_next = 1'b0;
          if (msg_ok && (held_count != '0)) begin
            rep_next.accepted = 1'b1;
            mod_req.start     = 1'b1;
            mod_req.x         = XW'(write_ptr) + XW'(len) - XW'(1);
            state_next        = ST_WT;
          end else begin
            state_next = ST_REPORT;
          end
        end
      end
      ST_WT: begin
        if (mod_rsp.done) begin
          write_top_next = mod_rsp.r;
          if (!busy) begin
            mod_req.start = 1'b1;
            mod_req.x     = XW'(msg_start);
            state_next    = ST_LAUNCH;
          end else begin
            state_next = ST_REPORT;
          end
        end
      end
      ST_LAUNCH: begin
        if (mod_rsp.done) begin
          busy_next              = 1'b1;
          rep_next.start_segment = 1'b1;
          rep_next.seg_start     = mod_rsp.r[7:0];
          if (mod_rsp.r > write_top) begin
            rep_next.seg_len = len - mod_rsp.r;
            send_top_next    = len - 1'b1;
          end else begin
            rep_next.seg_len = write_top - mod_rsp.r + 1'b1;
            send_top_next    = write_top;
          end
          state_next = ST_REPORT;
        end
      end
      ST_FETCH: begin
        rep_next.read_data = fetch_ok ? ram_rdata : '0;
        state_next         = ST_REPORT;
      end
      ST_REPORT: begin
        res_push   = c.has_result;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      write_top   <= '0;
      send_top    <= '0;
      busy        <= 1'b0;
      error_tally <= '0;
      msg_ok      <= 1'b0;
      write_ptr   <= '0;
      msg_start   <= '0;
      held_len    <= '0;
      held_count  <= '0;
    end else begin
      state       <= state_next;
      write_top   <= write_top_next;
      send_top    <= send_top_next;
      busy        <= busy_next;
      error_tally <= error_tally_next;
      msg_ok      <= msg_ok_next;
      write_ptr   <= write_ptr_next;
      msg_start   <= msg_start_next;
      held_len    <= held_len_next;
      held_count  <= held_count_next;
    end
    c   <= c_next;
    rep <= rep_next;
  end

  dtrs_mod u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  dtrs_ram #(
    .W     (dtrs_pkg::DATA_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (c.data_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

[src/dtrs_checker.sv]
module dtrs_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input logic                         start_segment,
  input logic [dtrs_pkg::IDX_W-1:0]   seg_len,
  input logic                         busy_out,
  input logic [dtrs_pkg::TALLY_W-1:0] error_tally_out
);

  // queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // a launched segment leaves the engine busy
  a_launch_busy: assert property (@(posedge clk) disable iff (rst)
    (!empty && start_segment) |-> busy_out)
    else $error("segment launched while not busy");

  // a launched segment is never empty
  a_launch_len: assert property (@(posedge clk) disable iff (rst)
    (!empty && start_segment) |-> (seg_len != '0))
    else $error("segment of zero length");

  // a waiting word holds while not taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(error_tally_out) && $stable(seg_len)))
    else $error("result word changed while stalled");

endmodule

bind dma_tx_ring_segmenter_top dtrs_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .start_segment   (start_segment),
  .seg_len         (seg_len),
  .busy_out        (busy_out),
  .error_tally_out (error_tally_out)
);

[sim/dma_tx_ring_segmenter_checker.sv]
module dma_tx_ring_segmenter_checker
  import dtrs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [IDX_W-1:0]   cfg_wdata,
  input  logic               push,
  input  logic               full,
  input  logic [ACT_W-1:0]   action,
  input  logic [DATA_W-1:0]  data_byte,
  input  logic [MLEN_W-1:0]  msg_len,
  input  logic               first_flag,
  input  logic               last_flag,
  input  logic [IDX_W-1:0]   dma_remaining,
  input  logic [7:0]         fetch_index,
  input  logic               empty,
  input  logic               pop,
  input  logic               accepted,
  input  logic               start_segment,
  input  logic [7:0]         seg_start,
  input  logic [IDX_W-1:0]   seg_len,
  input  logic               busy_out,
  input  logic [TALLY_W-1:0] error_tally_out,
  input  logic [DATA_W-1:0]  read_data,
  output int                 fails,
  output int                 waiting,
  output logic [255:0]       stored_map
);

  logic [7:0]         ring_mem [256];
  logic [255:0]       filled;
  logic [IDX_W-1:0]   ring_len_reg;
  int unsigned        wr_top, snd_top, wr_ptr, msg_base, want_len, got_count;
  bit                 engine_busy, taking_msg;
  logic [TALLY_W-1:0] err_count;
  res_t               results_due [$];
  res_t               want, fresh;

  function automatic int unsigned span();
    if (ring_len_reg < 2) return 2;
    if (ring_len_reg > 256) return 256;
    return 32'(ring_len_reg);
  endfunction

  function automatic void open_segment(input int unsigned base, input int unsigned n,
                                       inout res_t r);
    int unsigned cnt;
    base = base % n;
    if (base > wr_top) begin
      cnt = n - base;
      snd_top = n - 1;
    end else begin
      cnt = wr_top - base + 1;
      snd_top = wr_top;
    end
    engine_busy = 1'b1;
    r.start_segment = 1'b1;
    r.seg_start = base[7:0];
    r.seg_len = cnt[IDX_W-1:0];
  endfunction

  function automatic bit next_result(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] db,
                                     input logic [MLEN_W-1:0] ml, input logic ff,
                                     input logic lf, input logic [IDX_W-1:0] rem,
                                     input logic [7:0] fi, output res_t r);
    int unsigned n;
    int occ;
    n = span();
    r = '0;
    case (act)
      ACT_BYTE: begin
        if (ff) begin
          taking_msg = 1'b0;
          if (ml != 0 && 32'(ml) <= n) begin
            if (engine_busy) begin
              if (snd_top > wr_top) occ = int'(wr_top) + int'(n) + int'(rem) - int'(snd_top);
              else occ = int'(wr_top) - int'(snd_top) + int'(rem);
              if (occ >= 0 && int'(ml) <= int'(n) - occ) begin
                taking_msg = 1'b1;
                msg_base = (wr_top + 1) % n;
              end
            end else begin
              wr_top = 0;
              snd_top = 0;
              msg_base = 0;
              taking_msg = 1'b1;
            end
          end
          if (taking_msg) begin
            wr_ptr = msg_base;
            want_len = 32'(ml);
            got_count = 0;
          end
        end
        if (taking_msg && got_count < want_len) begin
          if (wr_ptr < 256) begin
            ring_mem[wr_ptr] = db;
            filled[wr_ptr] = 1'b1;
          end
          wr_ptr = (wr_ptr + 1) % n;
          got_count++;
        end
        if (!lf) return 1'b0;
        if (taking_msg && got_count > 0) begin
          r.accepted = 1'b1;
          wr_top = (wr_ptr + n - 1) % n;
          if (!engine_busy) open_segment(msg_base, n, r);
        end
        taking_msg = 1'b0;
      end
      ACT_DONE: begin
        if (engine_busy) begin
          if (snd_top != wr_top) open_segment((snd_top + 1) % n, n, r);
          else engine_busy = 1'b0;
        end
      end
      ACT_ERR: err_count = err_count + 1'b1;
      ACT_FETCH: r.read_data = ring_mem[fi];
      default: ;
    endcase
    r.busy_out = engine_busy;
    r.error_tally_out = err_count;
    return 1'b1;
  endfunction

  task automatic check_field(input string what, input logic [31:0] exp, input logic [31:0] got);
    if (got !== exp) begin
      $display("%0t %s: expected %0h actual %0h", $time, what, exp, got);
      fails++;
    end
  endtask

  initial fails = 0;

  always @(posedge clk) begin
    if (rst) begin
      filled = '0;
      ring_len_reg = RING_LEN_RESET;
      wr_top = 0;
      snd_top = 0;
      wr_ptr = 0;
      msg_base = 0;
      want_len = 0;
      got_count = 0;
      engine_busy = 1'b0;
      taking_msg = 1'b0;
      err_count = '0;
      results_due.delete();
      waiting <= 0;
      stored_map <= '0;
    end else begin
      if (cfg_wen) ring_len_reg = cfg_wdata;
      if (pop && !empty) begin
        if (results_due.size() == 0) begin
          $display("%0t result word with nothing expected", $time);
          fails++;
        end else begin
          want = results_due.pop_front();
          check_field("accepted", 32'(want.accepted), 32'(accepted));
          check_field("start_segment", 32'(want.start_segment), 32'(start_segment));
          check_field("seg_start", 32'(want.seg_start), 32'(seg_start));
          check_field("seg_len", 32'(want.seg_len), 32'(seg_len));
          check_field("busy_out", 32'(want.busy_out), 32'(busy_out));
          check_field("error_tally_out", want.error_tally_out, error_tally_out);
          check_field("read_data", 32'(want.read_data), 32'(read_data));
        end
      end
      if (push && !full) begin
        if (next_result(action, data_byte, msg_len, first_flag, last_flag, dma_remaining,
                        fetch_index, fresh))
          results_due.push_back(fresh);
      end
      waiting <= results_due.size();
      stored_map <= filled;
    end
  end

endmodule

[sim/dma_tx_ring_segmenter_top_test.sv]
module dma_tx_ring_segmenter_top_test;
  import dtrs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE = 60;
  localparam int PHASE_WORDS = 120;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wen = 1'b0;
  logic [IDX_W-1:0]   cfg_wdata = '0;
  logic               push = 1'b0;
  logic               full;
  logic [ACT_W-1:0]   action = ACT_BYTE;
  logic [DATA_W-1:0]  data_byte = '0;
  logic [MLEN_W-1:0]  msg_len = '0;
  logic               first_flag = 1'b0;
  logic               last_flag = 1'b0;
  logic [IDX_W-1:0]   dma_remaining = '0;
  logic [7:0]         fetch_index = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic               accepted, start_segment, busy_out;
  logic [7:0]         seg_start;
  logic [IDX_W-1:0]   seg_len;
  logic [TALLY_W-1:0] error_tally_out;
  logic [DATA_W-1:0]  read_data;

  int           fails, waiting;
  logic [255:0] filled_map;
  int           cycles = 0;
  int unsigned  words = 0;
  int unsigned  span_now = 256;
  int unsigned  quota;
  bit           steady = 1'b0;
  logic [8:0]   plan [8];

  dma_tx_ring_segmenter_top dut (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .push(push), .full(full), .action(action), .data_byte(data_byte), .msg_len(msg_len),
    .first_flag(first_flag), .last_flag(last_flag), .dma_remaining(dma_remaining),
    .fetch_index(fetch_index), .empty(empty), .pop(pop), .accepted(accepted),
    .start_segment(start_segment), .seg_start(seg_start), .seg_len(seg_len),
    .busy_out(busy_out), .error_tally_out(error_tally_out), .read_data(read_data)
  );

  dma_tx_ring_segmenter_checker checker_i (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .push(push), .full(full), .action(action), .data_byte(data_byte), .msg_len(msg_len),
    .first_flag(first_flag), .last_flag(last_flag), .dma_remaining(dma_remaining),
    .fetch_index(fetch_index), .empty(empty), .pop(pop), .accepted(accepted),
    .start_segment(start_segment), .seg_start(seg_start), .seg_len(seg_len),
    .busy_out(busy_out), .error_tally_out(error_tally_out), .read_data(read_data),
    .fails(fails), .waiting(waiting), .stored_map(filled_map)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("dma_tx_ring_segmenter_top: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= steady || ($urandom_range(99) >= 9);
  end

  task automatic put_word(input logic [ACT_W-1:0] act, input logic [7:0] db,
                          input logic [15:0] ml, input logic ff, input logic lf,
                          input logic [8:0] rem, input logic [7:0] fi);
    if (!steady && $urandom_range(99) < 9) begin
      push <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    push <= 1'b1;
    action <= act;
    data_byte <= db;
    msg_len <= ml;
    first_flag <= ff;
    last_flag <= lf;
    dma_remaining <= rem;
    fetch_index <= fi;
    @(posedge clk);
    while (full) @(posedge clk);
    words++;
  endtask

  function automatic logic [8:0] pick_remaining();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return 9'($urandom_range(8));
    if (r < 80) return 9'($urandom_range(40));
    return 9'($urandom_range(256));
  endfunction

  function automatic int unsigned msg_size();
    if ($urandom_range(99) < 92) return $urandom_range((span_now < 12) ? span_now : 12, 1);
    return $urandom_range(span_now, 1);
  endfunction

  task automatic send_message(input int unsigned mlen, input int unsigned nbytes,
                              input bit opened, input bit closed);
    logic [8:0] rem;
    rem = pick_remaining();
    for (int i = 0; i < nbytes; i++)
      put_word(ACT_BYTE, 8'($urandom), mlen[15:0], opened && i == 0,
               closed && i == nbytes - 1, (i == 0) ? rem : 9'($urandom), 8'($urandom));
  endtask

  task automatic send_event(input logic [ACT_W-1:0] act);
    put_word(act, 8'($urandom), 16'($urandom), 1'($urandom), 1'($urandom),
             pick_remaining(), 8'($urandom));
  endtask

  // fetch only from entries already written
  task automatic do_fetch();
    int unsigned idx;
    bit found;
    found = 1'b0;
    for (int k = 0; k < 64 && !found; k++) begin
      idx = $urandom_range(255);
      found = filled_map[idx];
    end
    if (found)
      put_word(ACT_FETCH, 8'($urandom), 16'($urandom), 1'($urandom), 1'($urandom),
               9'($urandom), idx[7:0]);
    else
      send_event(ACT_ERR);
  endtask

  task automatic random_step();
    int unsigned pick, len;
    pick = $urandom_range(99);
    len = msg_size();
    if (pick < 55) begin
      send_message(len, len, 1'b1, 1'b1);
    end else if (pick < 70) begin
      send_event(ACT_DONE);
    end else if (pick < 75) begin
      send_event(ACT_ERR);
    end else if (pick < 87) begin
      do_fetch();
    end else begin
      case ($urandom_range(5))
        0: send_message(0, $urandom_range(2, 1), 1'b1, 1'b1);
        1: send_message(($urandom_range(1) != 0) ? 65535 : span_now + $urandom_range(40, 1),
                        $urandom_range(3, 1), 1'b1, 1'b1);
        2: send_message(len + $urandom_range(5, 1), len, 1'b1, 1'b1);
        3: send_message(len, len + $urandom_range(3, 1), 1'b1, 1'b1);
        4: send_message($urandom_range(65535), $urandom_range(3, 1), 1'b0, 1'($urandom));
        default: begin
          send_message(len + 2, $urandom_range(len + 1, 1), 1'b1, 1'b0);
          send_message(len, len, 1'b1, 1'b1);
        end
      endcase
    end
  endtask

  task automatic retune(input logic [8:0] v);
    push <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    span_now = (v < 2) ? 2 : (v > 256) ? 256 : 32'(v);
  endtask

  initial begin
    plan = '{9'd2, 9'd511, 9'd7, 9'd0, 9'd100, 9'd1, 9'd256, 9'($urandom_range(255, 3))};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    put_word(ACT_DONE, 8'h00, 16'h0000, 1'b0, 1'b0, 9'd0, 8'h00);
    put_word(ACT_ERR, 8'h00, 16'h0000, 1'b0, 1'b0, 9'd0, 8'h00);
    put_word(ACT_BYTE, 8'h11, 16'd0, 1'b1, 1'b1, 9'd0, 8'h00);
    put_word(ACT_BYTE, 8'h22, 16'hffff, 1'b1, 1'b1, 9'd0, 8'hff);
    put_word(ACT_BYTE, 8'h33, 16'd1, 1'b0, 1'b1, 9'd0, 8'h00);
    put_word(ACT_BYTE, 8'h00, 16'd3, 1'b1, 1'b0, 9'd0, 8'h00);
    put_word(ACT_BYTE, 8'hff, 16'd3, 1'b0, 1'b0, 9'd0, 8'h00);
    put_word(ACT_BYTE, 8'ha5, 16'd3, 1'b0, 1'b1, 9'd0, 8'h00);
    // busy and no room left
    put_word(ACT_BYTE, 8'h44, 16'd1, 1'b1, 1'b1, 9'd256, 8'h00);
    // extra byte beyond the length
    put_word(ACT_BYTE, 8'h55, 16'd2, 1'b1, 1'b0, 9'd0, 8'h00);
    put_word(ACT_BYTE, 8'h66, 16'd2, 1'b0, 1'b0, 9'd0, 8'h00);
    put_word(ACT_BYTE, 8'h77, 16'd2, 1'b0, 1'b1, 9'd0, 8'h00);
    // short message
    put_word(ACT_BYTE, 8'h88, 16'd5, 1'b1, 1'b0, 9'd1, 8'h00);
    put_word(ACT_BYTE, 8'h99, 16'd5, 1'b0, 1'b1, 9'd1, 8'h00);
    // new first byte mid message
    put_word(ACT_BYTE, 8'haa, 16'd4, 1'b1, 1'b0, 9'd2, 8'h00);
    put_word(ACT_BYTE, 8'hbb, 16'd1, 1'b1, 1'b1, 9'd2, 8'h00);
    put_word(ACT_FETCH, 8'h00, 16'h0000, 1'b0, 1'b0, 9'd0, 8'd2);
    put_word(ACT_FETCH, 8'hff, 16'hffff, 1'b1, 1'b1, 9'd511, 8'd0);
    put_word(ACT_DONE, 8'h00, 16'h0000, 1'b0, 1'b0, 9'd0, 8'h00);
    put_word(ACT_DONE, 8'h00, 16'h0000, 1'b0, 1'b0, 9'd0, 8'h00);
    put_word(ACT_DONE, 8'h00, 16'h0000, 1'b0, 1'b0, 9'd0, 8'h00);
    put_word(ACT_DONE, 8'h00, 16'h0000, 1'b0, 1'b0, 9'd0, 8'h00);

    for (int p = 0; p < 8; p++) begin
      retune(plan[p]);
      steady = (p == 4);
      quota = words + PHASE_WORDS;
      while (words < quota) random_step();
    end
    steady = 1'b0;

    push <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fails == 0) $display("dma_tx_ring_segmenter_top: match");
    else $display("dma_tx_ring_segmenter_top: mismatch");
    $finish;
  end

endmodule

[sim.f]
src/dtrs_pkg.sv
src/dtrs_ram.sv
src/dtrs_fifo.sv
src/dtrs_front.sv
src/dtrs_mod.sv
src/dtrs_back.sv
src/dma_tx_ring_segmenter_top.sv
src/dtrs_checker.sv
sim/dma_tx_ring_segmenter_checker.sv
sim/dma_tx_ring_segmenter_top_test.sv
